// ----- hw/rtl/cpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Correlation peak detector package
// Shared widths, types, register codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

   localparam int MAG_BITS       = 32;
   localparam int COUNT_BITS     = 24;
   localparam int INDEX_BITS     = 24;
   localparam int CFG_BITS       = 8;
   localparam int HITS_BITS      = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int PROD_BITS      = MAG_BITS + CFG_BITS;
   localparam int DIV_STEP_BITS  = $clog2(MAG_BITS);

   typedef logic [MAG_BITS-1:0]       mag_type;
   typedef logic [COUNT_BITS-1:0]     count_type;
   typedef logic [INDEX_BITS-1:0]     index_type;
   typedef logic [CFG_BITS-1:0]       cfg_type;
   typedef logic [HITS_BITS-1:0]      hits_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [PROD_BITS-1:0]      prod_type;

   localparam csr_index_type CSR_THRESHOLD_FACTOR = csr_index_type'(0);
   localparam csr_index_type CSR_HIT_LIMIT        = csr_index_type'(1);

   localparam cfg_type   THRESHOLD_RESET = cfg_type'(30);
   localparam hits_type  HIT_LIMIT_RESET = hits_type'(20);
   localparam count_type COUNT_MAX       = '1;

endpackage : cpd_pkg

`default_nettype wire

// ----- hw/rtl/cpd_channels.sv -----
// ----------------------------------------------------------------------------
// Correlation peak detector channels
// Valid/ready interfaces for the sample, result and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpd_req_if import cpd_pkg::*; ();
   logic    valid;
   logic    ready;
   mag_type magnitude;
   logic    invalid;
   logic    block_end;

   modport source (output valid, magnitude, invalid, block_end, input ready);
   modport sink   (input valid, magnitude, invalid, block_end, output ready);
endinterface : cpd_req_if

interface cpd_rsp_if import cpd_pkg::*; ();
   logic      valid;
   logic      ready;
   mag_type   mean;
   mag_type   peak_value;
   index_type peak_index;
   logic      accepted;
   logic      active;

   modport source (output valid, mean, peak_value, peak_index, accepted, active,
                   input ready);
   modport sink   (input valid, mean, peak_value, peak_index, accepted, active,
                   output ready);
endinterface : cpd_rsp_if

interface cpd_csr_if import cpd_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   cfg_type       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface : cpd_csr_if

`default_nettype wire

// ----- hw/rtl/cpd_divider.sv -----
// ----------------------------------------------------------------------------
// Correlation peak detector divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_divider
   import cpd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   input  wire mag_type   dividend,
   input  wire count_type divisor,
   output mag_type        quotient,
   output logic           done
);

   localparam logic [DIV_STEP_BITS-1:0] STEP_LAST = DIV_STEP_BITS'(MAG_BITS - 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic [COUNT_BITS:0]      rem_ff, rem_in;
   mag_type                  quo_ff, quo_in;
   count_type                den_ff, den_in;

   logic [COUNT_BITS:0] shifted;
   logic [COUNT_BITS:0] trial;
   logic                fits;

   assign shifted = {rem_ff[COUNT_BITS-1:0], quo_ff[MAG_BITS-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? trial : shifted;
         quo_in  = {quo_ff[MAG_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule : cpd_divider

`default_nettype wire

// ----- hw/rtl/correlation_peak_detector_unit.sv -----
// ----------------------------------------------------------------------------
// Correlation peak detector unit
// A used sample (detector active, not invalid) runs through the 32-step serial
// divider and the update, multiply, compare and output steps; a skipped sample
// goes straight to the output step. A new sample is taken only once the last
// one has left the output step; a stalled result channel holds it there.
// Reset: synchronous, clears the sequencer, detector state and result valid;
// loads threshold 30, hit limit 20.
// ----------------------------------------------------------------------------
`default_nettype none

module correlation_peak_detector_unit
   import cpd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   cpd_req_if.sink   req_chan,
   cpd_rsp_if.source rsp_chan,
   cpd_csr_if.sink   csr_chan
);

   // Sequencer states. A used sample walks through all of them; a sample
   // that is skipped or marked invalid goes straight to the output state.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_UPD  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_CMP  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;

   // Configuration and detector state.
   cfg_type   thresh_ff, thresh_in;
   hits_type  hits_ff, hits_in;
   logic      detect_ff, detect_in;
   mag_type   mean_ff, mean_in;
   mag_type   max_ff, max_in;
   count_type max_pos_ff, max_pos_in;
   count_type count_ff, count_in;

   // Per-sample working registers.
   mag_type   x_ff, x_in;
   logic      last_ff, last_in;
   logic      acc_ff, acc_in;
   logic      neg_ff, neg_in;
   count_type pos_ff, pos_in;
   prod_type  limit_ff, limit_in;

   // Output register.
   logic      rsp_valid_ff, rsp_valid_in;
   mag_type   rsp_mean_ff, rsp_mean_in;
   mag_type   rsp_peak_ff, rsp_peak_in;
   index_type rsp_index_ff, rsp_index_in;
   logic      rsp_acc_ff, rsp_acc_in;
   logic      rsp_active_ff, rsp_active_in;

   logic      req_xfer;
   logic      csr_xfer;
   logic      out_free;
   logic      div_start;
   mag_type   div_dividend;
   count_type count_next;
   mag_type   quotient;
   logic      div_done;
   logic      active_next;

   // The block takes a new sample only when the sequencer is idle. The
   // output register decouples it from the result side, so a result may
   // still wait for its transfer while the next sample is being worked on.
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign csr_xfer = csr_chan.valid && csr_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // The divisor is the one-based position of this sample, which saturates
   // together with the sample count.
   assign count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

   // The difference x - mean is split into sign and magnitude so that an
   // unsigned divider gives a quotient that truncates toward zero.
   assign div_dividend = (req_chan.magnitude >= mean_ff) ? req_chan.magnitude - mean_ff
                                                          : mean_ff - req_chan.magnitude;
   assign div_start    = req_xfer && detect_ff && !req_chan.invalid;

   // Activity is re-evaluated only at the end of a block, from the hit
   // counter as it stands after this sample.
   assign active_next = last_ff ? (hits_ff != '0) : detect_ff;

   cpd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_next),
      .quotient (quotient),
      .done     (div_done)
   );

   always_comb begin
      state_in      = state_ff;
      thresh_in     = thresh_ff;
      hits_in       = hits_ff;
      detect_in     = detect_ff;
      mean_in       = mean_ff;
      max_in        = max_ff;
      max_pos_in    = max_pos_ff;
      count_in      = count_ff;
      x_in          = x_ff;
      last_in       = last_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      pos_in        = pos_ff;
      limit_in      = limit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_mean_in   = rsp_mean_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_active_in = rsp_active_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               x_in    = req_chan.magnitude;
               last_in = req_chan.block_end;
               acc_in  = detect_ff;
               neg_in  = req_chan.magnitude < mean_ff;
               pos_in  = count_ff;
               if (detect_ff) begin
                  count_in = count_next;
               end
               state_in = div_start ? S_DIV : S_OUT;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            // The quotient never exceeds the difference, so the new mean
            // stays between the old mean and the sample.
            mean_in  = neg_ff ? mean_ff - quotient : mean_ff + quotient;
            state_in = S_MUL;
         end
         S_MUL: begin
            limit_in = PROD_BITS'(mean_ff) * PROD_BITS'(thresh_ff);
            state_in = S_CMP;
         end
         S_CMP: begin
            // A strict new maximum becomes the peak; if it also beats the
            // threshold times the updated mean, one hit is used up.
            if (x_ff > max_ff) begin
               max_in     = x_ff;
               max_pos_in = pos_ff;
               if (PROD_BITS'(x_ff) > limit_ff && hits_ff != '0) begin
                  hits_in = hits_ff - 1'b1;
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               detect_in     = active_next;
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = mean_ff;
               rsp_peak_in   = max_ff;
               rsp_index_in  = INDEX_BITS'(max_pos_ff);
               rsp_acc_in    = acc_ff;
               rsp_active_in = active_next;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register writes must come only while idle (not enforced). Writing the
      // hit limit reloads the hit counter; activity follows at a block end.
      if (csr_xfer) begin
         case (csr_chan.index)
            CSR_THRESHOLD_FACTOR: thresh_in = csr_chan.data;
            CSR_HIT_LIMIT:        hits_in   = csr_chan.data;
            default:              ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thresh_ff    <= THRESHOLD_RESET;
         hits_ff      <= HIT_LIMIT_RESET;
         detect_ff    <= 1'b1;
         mean_ff      <= '0;
         max_ff       <= '0;
         max_pos_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         hits_ff      <= hits_in;
         detect_ff    <= detect_in;
         mean_ff      <= mean_in;
         max_ff       <= max_in;
         max_pos_ff   <= max_pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      last_ff       <= last_in;
      acc_ff        <= acc_in;
      neg_ff        <= neg_in;
      pos_ff        <= pos_in;
      limit_ff      <= limit_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.mean       = rsp_mean_ff;
   assign rsp_chan.peak_value = rsp_peak_ff;
   assign rsp_chan.peak_index = rsp_index_ff;
   assign rsp_chan.accepted   = rsp_acc_ff;
   assign rsp_chan.active     = rsp_active_ff;

endmodule : correlation_peak_detector_unit

`default_nettype wire

// ----- hw/rtl/cpd_checker.sv -----
// ----------------------------------------------------------------------------
// Correlation peak detector checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_checker
   import cpd_pkg::*;
(
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      req_valid,
   input wire logic      req_ready,
   input wire logic      rsp_valid,
   input wire logic      rsp_ready,
   input wire mag_type   rsp_mean,
   input wire mag_type   rsp_peak_value,
   input wire index_type rsp_peak_index,
   input wire logic      rsp_accepted,
   input wire logic      rsp_active
);

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // Ready drops after each sample transfer.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sample taken while previous one is in progress");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn before its transfer");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_mean) && $stable(rsp_peak_value) && $stable(rsp_peak_index) &&
          $stable(rsp_accepted) && $stable(rsp_active)))
      else $error("result changed while stalled");

endmodule : cpd_checker

bind correlation_peak_detector_unit cpd_checker u_cpd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_mean       (rsp_chan.mean),
   .rsp_peak_value (rsp_chan.peak_value),
   .rsp_peak_index (rsp_chan.peak_index),
   .rsp_accepted   (rsp_chan.accepted),
   .rsp_active     (rsp_chan.active)
);

`default_nettype wire

// ----- tb/sv/correlation_peak_detector_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Correlation peak detector unit testbench
// Sends magnitude samples through the request channel and writes the two
// registers between phases. Every result is checked field by field against a
// cycle-free model of the running mean, peak and hit counter. Directed cases
// come first, then random blocks of samples, then a full-scale peak at the end.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module correlation_peak_detector_unit_tb;
   import cpd_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 12;
   // A used sample is the slowest to give its result. Add the longest sender
   // gap and receiver stall, and the limit still leaves a wide margin.
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 60;
   localparam int RANDOM_ITEMS  = 1080;
   localparam int MAX_REPORTED  = 10;

   // Register indexes with no register behind them; writes to them are ignored.
   localparam csr_index_type CSR_SPARE_LO = csr_index_type'(2);
   localparam csr_index_type CSR_SPARE_HI = csr_index_type'(3);

   typedef struct packed {
      mag_type   mean;
      mag_type   peak_value;
      index_type peak_index;
      logic      accepted;
      logic      active;
   } peak_report_type;

   logic clock = 1'b0;
   logic reset;

   cpd_req_if req_bus ();
   cpd_rsp_if rsp_bus ();
   cpd_csr_if csr_bus ();

   correlation_peak_detector_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Model state of the detector, matching the block right after reset.
   cfg_type   cfg_threshold = THRESHOLD_RESET;
   mag_type   trk_mean      = '0;
   mag_type   trk_peak      = '0;
   index_type trk_peak_pos  = '0;
   count_type trk_count     = '0;
   hits_type  trk_hits      = HIT_LIMIT_RESET;
   logic      trk_active    = 1'b1;

   // Results still owed by the block, oldest first.
   peak_report_type pending_reports[$];

   // Random idling on both channels; switched off for the last part of the run.
   bit idle_on = 1'b1;

   int samples_sent    = 0;
   int samples_used    = 0;
   int strong_peaks    = 0;
   int reg_writes      = 0;
   int reports_checked = 0;
   int mismatch_count  = 0;

   // Advances the model by one sample and returns the result it must produce.
   // The mean moves by (x - mean) / count with the quotient truncated toward
   // zero, and a new strict peak is a hit when it exceeds mean * threshold,
   // where the mean already includes this sample.
   function automatic peak_report_type track_sample(mag_type x, logic bad, logic last);
      peak_report_type r;
      count_type       slot;
      longint          diff;
      longint          quot;
      prod_type        bar;
      r.accepted = trk_active;
      if (trk_active) begin
         samples_used++;
         slot = trk_count;
         if (trk_count != COUNT_MAX) begin
            trk_count = trk_count + 1'b1;
         end
         if (!bad) begin
            diff     = longint'(x) - longint'(trk_mean);
            quot     = diff / longint'(trk_count);
            trk_mean = mag_type'(longint'(trk_mean) + quot);
            if (x > trk_peak) begin
               bar          = prod_type'(trk_mean) * prod_type'(cfg_threshold);
               trk_peak     = x;
               trk_peak_pos = index_type'(slot);
               if (prod_type'(x) > bar && trk_hits != '0) begin
                  trk_hits = trk_hits - 1'b1;
                  strong_peaks++;
               end
            end
         end
      end
      // Activity is looked at again only on the last sample of a block, even
      // when the detector is already stopped.
      if (last) begin
         trk_active = (trk_hits != '0);
      end
      r.mean       = trk_mean;
      r.peak_value = trk_peak;
      r.peak_index = trk_peak_pos;
      r.active     = trk_active;
      return r;
   endfunction

   task automatic flag_mismatch(string what, peak_report_type want, peak_report_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) begin
         $display("[%0t] mismatch: %s", $time, what);
         $display("   expected mean=%h peak=%h index=%h accepted=%b active=%b",
                  want.mean, want.peak_value, want.peak_index, want.accepted, want.active);
         $display("   actual   mean=%h peak=%h index=%h accepted=%b active=%b",
                  got.mean, got.peak_value, got.peak_index, got.accepted, got.active);
      end
   endtask

   // Sends one sample and returns at the edge of its transfer, with valid still
   // high. The caller then either sends again or lowers valid at once, so that
   // valid never gets two assignments in one time step.
   task automatic send_sample(mag_type mag, logic bad, logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.magnitude <= mag;
      req_bus.invalid   <= bad;
      req_bus.block_end <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_reports.push_back(track_sample(mag, bad, last));
      samples_sent++;
   endtask

   // Stops the sample stream and waits until every owed result has arrived.
   task automatic drain_reports();
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes only happen with the block idle.
   task automatic write_register(csr_index_type idx, cfg_type value);
      drain_reports();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_THRESHOLD_FACTOR) begin
         cfg_threshold = value;
      end else if (idx == CSR_HIT_LIMIT) begin
         // The hit counter is reloaded, but activity waits for a block end.
         trk_hits = value;
      end
      reg_writes++;
   endtask

   // Reset settings. Zero never becomes a peak, the mean falls with a small
   // sample (negative step truncated toward zero), an equal sample is not a
   // new peak, and invalid samples carry the high magnitude bits.
   task automatic test_directed_samples();
      send_sample(32'h0000_0000, 1'b0, 1'b0);
      send_sample(32'h0001_0000, 1'b0, 1'b0);
      send_sample(32'h0000_0001, 1'b0, 1'b0);
      send_sample(32'h0002_0000, 1'b0, 1'b0);
      send_sample(32'h0002_0000, 1'b0, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_sample(32'hAAAA_AAAA, 1'b1, 1'b0);
      send_sample(32'h5555_5555, 1'b1, 1'b1);
      send_sample(32'h0000_7FFF, 1'b0, 1'b1);
   endtask

   // A zero threshold makes every new peak a hit. More hits than the limit
   // leave the counter at its floor, and the block end stops detection. A new
   // hit limit does not restart detection until the next block end.
   task automatic test_threshold_zero();
      write_register(CSR_THRESHOLD_FACTOR, 8'd0);
      write_register(CSR_HIT_LIMIT, 8'd2);
      send_sample(trk_peak + 32'd1, 1'b0, 1'b0);
      send_sample(trk_peak + 32'd2, 1'b0, 1'b0);
      send_sample(trk_peak + 32'd3, 1'b0, 1'b1);
      send_sample(32'h0100_0000, 1'b0, 1'b1);
      write_register(CSR_HIT_LIMIT, 8'd1);
      send_sample(32'h0000_1234, 1'b0, 1'b0);
      send_sample(32'h0000_0000, 1'b0, 1'b1);
      send_sample(trk_peak + 32'd1, 1'b0, 1'b0);
   endtask

   // A hit limit of zero stops detection at the first block end. Writes to
   // the unused indexes change nothing. Then both registers at their extremes.
   task automatic test_hit_limit_zero();
      write_register(CSR_THRESHOLD_FACTOR, 8'd255);
      write_register(CSR_HIT_LIMIT, 8'd0);
      write_register(CSR_SPARE_LO, 8'hFF);
      write_register(CSR_SPARE_HI, 8'h00);
      send_sample(32'h0000_4000, 1'b0, 1'b1);
      send_sample(32'h0000_8000, 1'b0, 1'b0);
      write_register(CSR_THRESHOLD_FACTOR, 8'd1);
      write_register(CSR_HIT_LIMIT, 8'd255);
      send_sample(32'h0000_0100, 1'b0, 1'b1);
      send_sample(trk_peak + 32'h100, 1'b0, 1'b0);
   endtask

   // Random blocks of samples. The peak only ever grows, so new peaks are
   // built from the current one plus a step that grows with it; this keeps
   // new peaks and hits coming for the whole run. Quiet blocks keep the mean
   // low so that large threshold factors still see hits. Invalid samples carry
   // full 32-bit random values. Counter saturation would take 2^24 samples and
   // lies beyond the length of this run.
   task automatic test_random_blocks();
      int          sent;
      int          length;
      int          roll;
      bit          quiet;
      bit          bad;
      mag_type     mag;
      logic [33:0] bump;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= RANDOM_ITEMS * 85 / 100) begin
            idle_on = 1'b0;
         end
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 5))
               0:       write_register(CSR_THRESHOLD_FACTOR, 8'd0);
               1:       write_register(CSR_THRESHOLD_FACTOR, 8'd1);
               2:       write_register(CSR_THRESHOLD_FACTOR, 8'd255);
               default: write_register(CSR_THRESHOLD_FACTOR, cfg_type'($urandom_range(2, 40)));
            endcase
         end
         // Skipping the reload now and then lets the detector stay stopped.
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 7))
               0:       write_register(CSR_HIT_LIMIT, 8'd0);
               1:       write_register(CSR_HIT_LIMIT, 8'd1);
               2:       write_register(CSR_HIT_LIMIT, 8'd255);
               3:       write_register(CSR_HIT_LIMIT, cfg_type'($urandom_range(1, 255)));
               default: write_register(CSR_HIT_LIMIT, cfg_type'($urandom_range(1, 6)));
            endcase
         end
         repeat ($urandom_range(2, 6)) begin
            length = $urandom_range(1, 20);
            quiet  = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < length; k++) begin
               bad  = ($urandom_range(0, 9) == 0);
               roll = $urandom_range(0, 19);
               if (bad) begin
                  mag = $urandom();
               end else if (roll < 4) begin
                  bump = {2'b00, trk_peak} + 34'($urandom_range(1, (trk_peak >> 4) + 1024));
                  mag  = (bump > 34'hFFFF_FFF0) ? 32'hFFFF_FFF0 : mag_type'(bump);
               end else if (roll == 4) begin
                  mag = '0;
               end else if (quiet) begin
                  mag = $urandom_range(0, trk_peak >> 8);
               end else begin
                  mag = $urandom_range(0, trk_peak);
               end
               send_sample(mag, bad, k == length - 1);
               sent++;
            end
         end
      end
   endtask

   // Full-scale magnitude as a peak, an equal sample after it, and one just
   // below. This comes last because no later sample could become a peak.
   task automatic test_full_scale_peak();
      write_register(CSR_THRESHOLD_FACTOR, 8'd1);
      write_register(CSR_HIT_LIMIT, 8'd255);
      send_sample(32'h0000_0000, 1'b1, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
      send_sample(32'hFFFF_FFFE, 1'b0, 1'b0);
   endtask

   // The result channel stalls in random bursts; otherwise ready is high.
   initial begin : result_ready_driver
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // Each result transfer is compared with the oldest owed result.
   always @(posedge clock) begin : report_checker
      peak_report_type got;
      peak_report_type want;
      string           wrong;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.mean, rsp_bus.peak_value, rsp_bus.peak_index,
                 rsp_bus.accepted, rsp_bus.active};
         reports_checked++;
         if (pending_reports.size() == 0) begin
            flag_mismatch("result with no sample outstanding", '0, got);
         end else begin
            want  = pending_reports.pop_front();
            wrong = "";
            if (got.mean !== want.mean) wrong = {wrong, " mean"};
            if (got.peak_value !== want.peak_value) wrong = {wrong, " peak_value"};
            if (got.peak_index !== want.peak_index) wrong = {wrong, " peak_index"};
            if (got.accepted !== want.accepted) wrong = {wrong, " accepted"};
            if (got.active !== want.active) wrong = {wrong, " active"};
            if (wrong.len() != 0) begin
               flag_mismatch({"wrong field(s):", wrong}, want, got);
            end
         end
      end
   end

   // Ends the run when no transfer happens on any channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
               STALL_LIMIT, pending_reports.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin : run_tests
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.magnitude <= '0;
      req_bus.invalid   <= 1'b0;
      req_bus.block_end <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_THRESHOLD_FACTOR;
      csr_bus.data      <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_samples();
      test_threshold_zero();
      test_hit_limit_zero();
      test_random_blocks();
      test_full_scale_peak();

      // Wait out every owed result, then a stretch past the longest latency
      // so that a stray extra result would still be caught.
      drain_reports();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d samples, %0d taken while active, %0d strong peaks, %0d register writes.",
               samples_sent, samples_used, strong_peaks, reg_writes);
      $display("Checked %0d results, %0d mismatches, %0d still owed.",
               reports_checked, mismatch_count, pending_reports.size());
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule : correlation_peak_detector_unit_tb

`default_nettype wire
